// ----- src/mean_shift_mode_seek_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the mode seeker
// Concurrent checks on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MEAN_SHIFT_MODE_SEEK_MACROS_SVH
`define MEAN_SHIFT_MODE_SEEK_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define MSMS_AST_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define MSMS_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MSMS_AST_IMP(lbl, ante, cons, msg)
`define MSMS_AST_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- src/msms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msms_pkg
// Shared types and codes of the mean-shift mode seeker.
// ----------------------------------------------------------------------------
package msms_pkg;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_pt;

    // request function codes
    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_APPEND = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_CONV  = 2'd0;
    localparam logic [1:0] STAT_LIMIT = 2'd1;
    localparam logic [1:0] STAT_ZERO  = 2'd2;

    // register indexes (8-byte spacing)
    localparam logic [1:0] REG_K    = 2'd0;
    localparam logic [1:0] REG_EPS  = 2'd1;
    localparam logic [1:0] REG_MAXP = 2'd2;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

endpackage

// ----- src/msms_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msms_req_if
// Request channel: function code and one 3D point.
// ----------------------------------------------------------------------------
interface msms_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;

    modport source (output valid, func, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, func, coord_x, coord_y, coord_z, output ready);
endinterface

// ----- src/msms_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msms_rsp_if
// Result channel: mode, nearest stored point, pass count and status.
// ----------------------------------------------------------------------------
interface msms_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] mode_x;
    logic signed [31:0] mode_y;
    logic signed [31:0] mode_z;
    logic [9:0]         nearest_index;
    logic [7:0]         passes_used;
    logic [1:0]         status;

    modport source (output valid, mode_x, mode_y, mode_z, nearest_index, passes_used,
                    status, input ready);
    modport sink   (input valid, mode_x, mode_y, mode_z, nearest_index, passes_used,
                    status, output ready);
endinterface

// ----- src/msms_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msms_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module msms_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ----- src/msms_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msms_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msms_div #(
    parameter int DW = 65,
    parameter int VW = 28
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dvd,
    input  logic [VW-1:0] i_dvs,
    output logic          o_busy,
    output logic          o_done,
    output logic [DW-1:0] o_quo
);
    localparam int CNT_W = $clog2(DW + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_dvs;
    logic [DW-1:0]    r_q;
    logic             r_done;
    logic [VW:0]      w_sh;
    logic             w_ge;

    assign w_sh = {r_rem, r_q[DW-1]};
    assign w_ge = w_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(DW);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= r_cnt == CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dvd;
            r_rem <= '0;
            r_dvs <= i_dvs;
        end else if (r_cnt != '0) begin
            // remainder stays below the divisor, so VW bits hold it
            r_rem <= w_ge ? VW'(w_sh - {1'b0, r_dvs}) : w_sh[VW-1:0];
            r_q   <= {r_q[DW-2:0], w_ge};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_done = r_done;
    assign o_quo  = r_q;
endmodule

// ----- src/mean_shift_mode_seek.sv -----
`timescale 1ns / 1ps
// Sequence: a query runs passes over the N stored points (kernel stream, three
//   divides, control), then the nearest-point scan and the result.
// Throughput: one request in flight; the next is taken once the result leaves.
// Reset: synchronous; registers and point count return to reset values, store
//   contents stay undefined until written, no clearing pass.
// ----------------------------------------------------------------------------
// mean_shift_mode_seek
// Mean-shift mode seeker with Gaussian kernel over a RAM of 3D points.
// ----------------------------------------------------------------------------
`include "mean_shift_mode_seek_macros.svh"

module mean_shift_mode_seek #(
    parameter int MAX_POINTS        = 1024,
    parameter int EXP_TABLE_ENTRIES = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    msms_req_if.sink                          i_req,
    msms_rsp_if.source                        o_rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [msms_pkg::ADDR_W-1:0]       paddr,
    input  logic [msms_pkg::DATA_W-1:0]       pwdata,
    output logic [msms_pkg::DATA_W-1:0]       prdata,
    output logic                              pready
);
    localparam int AW    = MAX_POINTS > 1 ? $clog2(MAX_POINTS) : 1;
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int IW    = $clog2(EXP_TABLE_ENTRIES);
    localparam int PW    = 52 + $clog2(EXP_TABLE_ENTRIES + 1);
    localparam int TW_W  = 17 + CW;
    localparam int DVD_W = 65;
    localparam int NSTG  = 9;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SETUP = 8'b0000_0010,
        S_RUN   = 8'b0000_0100,
        S_DIVGO = 8'b0000_1000,
        S_DIVWT = 8'b0001_0000,
        S_CHK1  = 8'b0010_0000,
        S_CHK2  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    // ---------------- kernel table ----------------
    function automatic logic [63:0] tstep(input logic [63:0] t, input logic [63:0] y);
        logic [63:0] p;
        p = t * y;
        return p >> 32;
    endfunction

    function automatic logic [16:0] exp_entry(input int i);
        logic [63:0] y;
        logic [63:0] s;
        logic [63:0] t;
        if (i == 0) return 17'd65536;
        y = (64'(i) << 32) / EXP_TABLE_ENTRIES;
        s = 64'h1_0000_0000;
        t = 64'h1_0000_0000;
        t = tstep(t, y) / 64'd1;  s = s - t;
        t = tstep(t, y) / 64'd2;  s = s + t;
        t = tstep(t, y) / 64'd3;  s = s - t;
        t = tstep(t, y) / 64'd4;  s = s + t;
        t = tstep(t, y) / 64'd5;  s = s - t;
        t = tstep(t, y) / 64'd6;  s = s + t;
        t = tstep(t, y) / 64'd7;  s = s - t;
        t = tstep(t, y) / 64'd8;  s = s + t;
        t = tstep(t, y) / 64'd9;  s = s - t;
        t = tstep(t, y) / 64'd10; s = s + t;
        t = tstep(t, y) / 64'd11; s = s - t;
        t = tstep(t, y) / 64'd12; s = s + t;
        t = tstep(t, y) / 64'd13; s = s - t;
        t = tstep(t, y) / 64'd14; s = s + t;
        t = tstep(t, y) / 64'd15; s = s - t;
        t = tstep(t, y) / 64'd16; s = s + t;
        t = tstep(t, y) / 64'd17; s = s - t;
        t = tstep(t, y) / 64'd18; s = s + t;
        t = tstep(t, y) / 64'd19; s = s - t;
        t = tstep(t, y) / 64'd20; s = s + t;
        for (int r = 0; r < 4; r++) begin
            s = (s * s + 64'h8000_0000) >> 32;
        end
        return 17'((s + 64'h8000) >> 16);
    endfunction

    function automatic logic [EXP_TABLE_ENTRIES*17-1:0] build_tab();
        logic [EXP_TABLE_ENTRIES*17-1:0] v;
        for (int i = 0; i < EXP_TABLE_ENTRIES; i++) begin
            v[i*17 +: 17] = exp_entry(i);
        end
        return v;
    endfunction

    localparam logic [EXP_TABLE_ENTRIES*17-1:0] W_TAB = build_tab();

    function automatic logic [32:0] absdiff(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        return d[32] ? 33'(-d) : 33'(d);
    endfunction

    function automatic logic [65:0] sq33(input logic [32:0] u);
        return 66'(u) * 66'(u);
    endfunction

    // ---------------- registers ----------------
    t_state              r_state;
    logic [31:0]         r_k;
    logic [62:0]         r_eps;
    logic [7:0]          r_maxp;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       r_iss;
    logic                r_near;
    msms_pkg::t_pt       r_p;
    logic signed [31:0]  r_n [3];
    logic [7:0]          r_pass;
    logic [1:0]          r_stat;
    logic [1:0]          r_ax;
    logic [2:0]          r_neg;
    logic signed [63:0]  r_acc [3];
    logic [TW_W-1:0]     r_tw;
    logic                r_have;
    logic [AW-1:0]       r_best;
    logic [65:0]         r_bd2;
    logic [65:0]         r_csq [3];

    // pipeline
    logic [NSTG-1:0]     r_vld;
    logic [AW-1:0]       r_js [4];
    msms_pkg::t_pt       r_cs [1:7];
    logic [32:0]         r_ua [3];
    logic [65:0]         r_sq [3];
    logic [65:0]         r_d2;
    logic [63:0]         r_plo;
    logic [63:0]         r_pmid;
    logic                r_zd;
    logic [51:0]         r_s52;
    logic                r_ze;
    logic [IW-1:0]       r_idx;
    logic                r_zf;
    logic [16:0]         r_wg;
    logic [16:0]         r_wh;
    logic signed [49:0]  r_pr [3];

    // ---------------- store ----------------
    logic                w_we;
    logic [$bits(msms_pkg::t_pt)-1:0] w_wdata;
    msms_pkg::t_pt       w_rd;
    logic                w_acc_in;
    logic                w_qry;
    logic                w_iss;

    assign w_acc_in = i_req.valid && i_req.ready;
    assign w_qry    = w_acc_in && i_req.func == msms_pkg::FUNC_QUERY;
    assign w_we     = w_acc_in && i_req.func == msms_pkg::FUNC_APPEND
                      && r_cnt < CW'(MAX_POINTS);
    assign w_wdata  = {i_req.coord_x, i_req.coord_y, i_req.coord_z};
    assign w_iss    = r_state == S_RUN && r_iss < r_cnt;

    msms_ram #(.WIDTH($bits(msms_pkg::t_pt)), .DEPTH(MAX_POINTS)) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_cnt[AW-1:0]),
        .i_wdata(w_wdata),
        .i_raddr(r_iss[AW-1:0]),
        .o_rdata(w_rd)
    );

    // ---------------- divider ----------------
    logic                w_dstart;
    logic                w_dbusy;
    logic                w_ddone;
    logic [DVD_W-1:0]    w_quo;
    logic signed [63:0]  w_sel;
    logic [63:0]         w_mag;
    logic [DVD_W-1:0]    w_dvd;
    logic [31:0]         w_q32;

    assign w_dstart = r_state == S_DIVGO;
    assign w_sel    = r_acc[r_ax];
    assign w_mag    = w_sel[63] ? 64'(-w_sel) : 64'(w_sel);
    // round half away from zero on the magnitude
    assign w_dvd    = {1'b0, w_mag} + DVD_W'(r_tw >> 1);
    assign w_q32    = w_quo[31:0];

    msms_div #(.DW(DVD_W), .VW(TW_W)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_dstart),
        .i_dvd  (w_dvd),
        .i_dvs  (r_tw),
        .o_busy (w_dbusy),
        .o_done (w_ddone),
        .o_quo  (w_quo)
    );

    // ---------------- kernel pipeline ----------------
    logic [64:0]         w_sumE;
    logic [PW-1:0]       w_prodF;
    logic [65:0]         w_shift;

    assign w_sumE  = 65'({r_pmid[19:0], 32'b0}) + 65'(r_plo);
    assign w_prodF = PW'(r_s52) * PW'(EXP_TABLE_ENTRIES);
    assign w_shift = r_csq[0] + r_csq[1] + r_csq[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], w_iss};
        end
    end

    always_ff @(posedge i_clk) begin
        r_js[0] <= r_iss[AW-1:0];
        for (int s = 1; s < 4; s++) begin
            r_js[s] <= r_js[s-1];
        end
        r_cs[1] <= w_rd;
        for (int s = 2; s < 8; s++) begin
            r_cs[s] <= r_cs[s-1];
        end
        // stage A: per-axis distance
        r_ua[0] <= absdiff(r_p.x, w_rd.x);
        r_ua[1] <= absdiff(r_p.y, w_rd.y);
        r_ua[2] <= absdiff(r_p.z, w_rd.z);
        // stage B: squares
        for (int a = 0; a < 3; a++) begin
            r_sq[a] <= sq33(r_ua[a]);
        end
        // stage C: squared distance, Q32.32
        r_d2 <= r_sq[0] + r_sq[1] + r_sq[2];
        // stage D: times k
        r_plo  <= 64'(r_d2[31:0]) * 64'(r_k);
        r_pmid <= 64'(r_d2[63:32]) * 64'(r_k);
        r_zd   <= r_d2[65:64] != 2'b0;
        // stage E: Q48.48 argument, out of table range gives zero weight
        r_s52 <= w_sumE[51:0];
        r_ze  <= r_zd || r_pmid >= 64'h10_0000 || w_sumE[64:52] != '0;
        // stage F: table index
        r_idx <= w_prodF[52 +: IW];
        r_zf  <= r_ze;
        // stage G: weight
        if (r_k == '0) begin
            r_wg <= W_TAB[16:0];
        end else if (r_zf) begin
            r_wg <= '0;
        end else begin
            r_wg <= W_TAB[r_idx*17 +: 17];
        end
        // stage H: weighted coordinates
        r_wh    <= r_wg;
        r_pr[0] <= $signed({1'b0, r_wg}) * r_cs[7].x;
        r_pr[1] <= $signed({1'b0, r_wg}) * r_cs[7].y;
        r_pr[2] <= $signed({1'b0, r_wg}) * r_cs[7].z;
        // convergence test squares
        r_csq[0] <= sq33(absdiff(r_n[0], r_p.x));
        r_csq[1] <= sq33(absdiff(r_n[1], r_p.y));
        r_csq[2] <= sq33(absdiff(r_n[2], r_p.z));
    end

    // ---------------- control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= 32'd65536;
            r_eps   <= 63'd4294967;
            r_maxp  <= 8'd100;
            r_cnt   <= '0;
            r_iss   <= '0;
            r_near  <= 1'b0;
            r_have  <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                unique case (paddr[4:3])
                    msms_pkg::REG_K:    r_k    <= pwdata[31:0];
                    msms_pkg::REG_EPS:  r_eps  <= pwdata[62:0];
                    msms_pkg::REG_MAXP: r_maxp <= pwdata[7:0];
                    default: ;
                endcase
            end
            if (w_iss) begin
                r_iss <= r_iss + 1'b1;
            end
            if (r_vld[NSTG-1]) begin
                r_tw <= r_tw + TW_W'(r_wh);
                for (int a = 0; a < 3; a++) begin
                    r_acc[a] <= r_acc[a] + 64'(r_pr[a]);
                end
            end
            // nearest scan, first index wins ties
            if (r_vld[3] && r_near && (!r_have || r_d2 < r_bd2)) begin
                r_have <= 1'b1;
                r_best <= r_js[3];
                r_bd2  <= r_d2;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_acc_in) begin
                        unique case (i_req.func)
                            msms_pkg::FUNC_CLEAR: r_cnt <= '0;
                            msms_pkg::FUNC_APPEND: begin
                                if (w_we) r_cnt <= r_cnt + 1'b1;
                            end
                            msms_pkg::FUNC_QUERY: begin
                                r_p     <= {i_req.coord_x, i_req.coord_y, i_req.coord_z};
                                r_pass  <= '0;
                                r_state <= S_SETUP;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SETUP: begin
                    r_iss <= '0;
                    if (r_pass >= r_maxp) begin
                        r_stat  <= msms_pkg::STAT_LIMIT;
                        r_near  <= 1'b1;
                        r_have  <= 1'b0;
                        r_best  <= '0;
                    end else begin
                        r_pass  <= r_pass + 1'b1;
                        r_near  <= 1'b0;
                        r_tw    <= '0;
                        for (int a = 0; a < 3; a++) r_acc[a] <= '0;
                    end
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (r_iss == r_cnt && r_vld == '0) begin
                        if (r_near) begin
                            r_state <= S_DONE;
                        end else if (r_tw == '0) begin
                            r_stat  <= msms_pkg::STAT_ZERO;
                            r_near  <= 1'b1;
                            r_have  <= 1'b0;
                            r_best  <= '0;
                            r_iss   <= '0;
                        end else begin
                            r_ax    <= 2'd0;
                            r_state <= S_DIVGO;
                        end
                    end
                end
                S_DIVGO: begin
                    r_neg[r_ax] <= w_sel[63];
                    r_state     <= S_DIVWT;
                end
                S_DIVWT: begin
                    if (w_ddone) begin
                        r_n[r_ax] <= r_neg[r_ax] ? -$signed(w_q32) : $signed(w_q32);
                        if (r_ax == 2'd2) begin
                            r_state <= S_CHK1;
                        end else begin
                            r_ax    <= r_ax + 1'b1;
                            r_state <= S_DIVGO;
                        end
                    end
                end
                S_CHK1: r_state <= S_CHK2;
                S_CHK2: begin
                    r_p <= {r_n[0], r_n[1], r_n[2]};
                    if (w_shift <= {3'b0, r_eps}) begin
                        r_stat  <= msms_pkg::STAT_CONV;
                        r_near  <= 1'b1;
                        r_have  <= 1'b0;
                        r_best  <= '0;
                        r_iss   <= '0;
                        r_state <= S_RUN;
                    end else begin
                        r_state <= S_SETUP;
                    end
                end
                S_DONE: begin
                    if (o_rsp.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------- ports ----------------
    assign i_req.ready         = r_state == S_IDLE;
    assign o_rsp.valid         = r_state == S_DONE;
    assign o_rsp.mode_x        = r_p.x;
    assign o_rsp.mode_y        = r_p.y;
    assign o_rsp.mode_z        = r_p.z;
    assign o_rsp.nearest_index = 10'(r_best);
    assign o_rsp.passes_used   = r_pass;
    assign o_rsp.status        = r_stat;

    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[4:3])
            msms_pkg::REG_K:    prdata = {32'b0, r_k};
            msms_pkg::REG_EPS:  prdata = {1'b0, r_eps};
            msms_pkg::REG_MAXP: prdata = {56'b0, r_maxp};
            default:            prdata = '0;
        endcase
    end

    // ---------------- checks ----------------
    `MSMS_AST_IMP(a_pipe_drained, r_state == S_DIVGO, r_vld == '0, "divide with pipe busy")
    `MSMS_AST_IMP(a_div_idle, w_dstart, !w_dbusy, "divider restarted while busy")
    `MSMS_AST_IMP(a_pass_cap, o_rsp.valid, r_pass <= r_maxp, "pass count over limit")
    `MSMS_AST_NXT(a_query_start, w_qry, r_state == S_SETUP, "query did not start")
endmodule

// ----- sim/msms_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msms_checker
// Watches the request, result and register channels of the mode seeker,
// predicts every query result from its own copy of the store and registers,
// and compares each result field by field in order.
// ----------------------------------------------------------------------------
module msms_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    msms_req_if                         req,
    msms_rsp_if                         rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [msms_pkg::ADDR_W-1:0] paddr,
    input  logic [msms_pkg::DATA_W-1:0] pwdata,
    input  logic                        pready,
    output int                          o_errors,
    output int                          o_pending
);
    localparam int MAX_PTS = 1024;
    localparam int EXP_N   = 256;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [9:0]         idx;
        logic [7:0]         passes;
        logic [1:0]         status;
    } t_mode_result;

    logic signed [31:0] pts_x [MAX_PTS];
    logic signed [31:0] pts_y [MAX_PTS];
    logic signed [31:0] pts_z [MAX_PTS];
    int                 pt_count;
    logic [31:0]        k_reg;
    logic [62:0]        eps_reg;
    logic [7:0]         maxp_reg;
    logic [16:0]        wtab [EXP_N];
    t_mode_result       modes_due[$];
    int                 errors;

    assign o_errors  = errors;
    assign o_pending = modes_due.size();

    function automatic logic [16:0] exp_entry(int i);
        logic [63:0]  y, s, term;
        logic [127:0] p;
        if (i == 0) return 17'd65536;
        y    = (64'(i) << 32) / EXP_N;
        s    = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int n = 1; n <= 20; n++) begin
            p    = {64'd0, term} * {64'd0, y};
            term = 64'(p >> 32) / 64'(n);
            if (n % 2 == 1) s = s - term;
            else s = s + term;
        end
        for (int r = 0; r < 4; r++) begin
            p = {64'd0, s} * {64'd0, s} + (128'd1 << 31);
            s = 64'(p >> 32);
        end
        return 17'((s + 64'd32768) >> 16);
    endfunction

    function automatic logic [65:0] sq33(longint d);
        logic [32:0] u;
        u = d < 0 ? 33'(-d) : 33'(d);
        return {33'd0, u} * {33'd0, u};
    endfunction

    function automatic logic [66:0] dist_sq(logic signed [31:0] ax, logic signed [31:0] ay,
                                            logic signed [31:0] az, int j);
        return 67'(sq33(longint'(ax) - longint'(pts_x[j])))
             + 67'(sq33(longint'(ay) - longint'(pts_y[j])))
             + 67'(sq33(longint'(az) - longint'(pts_z[j])));
    endfunction

    // t = d2 * k in Q48.48; table index is t / 2^44, past 2^52 the weight is zero
    function automatic logic [16:0] kernel_weight(logic [66:0] d2);
        logic [98:0] t;
        if (k_reg == 0) return wtab[0];
        t = {32'd0, d2} * {67'd0, k_reg};
        if (t >= (99'd1 << 52)) return 17'd0;
        return wtab[t[51:44]];
    endfunction

    function automatic logic signed [31:0] round_div(longint s, longint unsigned tw);
        longint unsigned mag, q;
        mag = s < 0 ? longint'(0) - s : s;
        q   = (mag + tw / 2) / tw;
        return s < 0 ? -32'(q) : 32'(q);
    endfunction

    function automatic t_mode_result seek_mode(logic signed [31:0] qx, logic signed [31:0] qy,
                                               logic signed [31:0] qz);
        t_mode_result    r;
        logic signed [31:0] px, py, pz, nx, ny, nz;
        longint          sx, sy, sz, wl;
        longint unsigned tw;
        logic [66:0]     shift, d2, best_d2;
        int              passes;
        px = qx; py = qy; pz = qz;
        passes = 0;
        while (1) begin
            if (passes >= maxp_reg) begin
                r.status = msms_pkg::STAT_LIMIT;
                break;
            end
            passes++;
            sx = 0; sy = 0; sz = 0; tw = 0;
            for (int j = 0; j < pt_count; j++) begin
                wl = longint'(kernel_weight(dist_sq(px, py, pz, j)));
                tw += wl;
                sx += wl * longint'(pts_x[j]);
                sy += wl * longint'(pts_y[j]);
                sz += wl * longint'(pts_z[j]);
            end
            if (tw == 0) begin
                r.status = msms_pkg::STAT_ZERO;
                break;
            end
            nx = round_div(sx, tw);
            ny = round_div(sy, tw);
            nz = round_div(sz, tw);
            shift = 67'(sq33(longint'(nx) - longint'(px)))
                  + 67'(sq33(longint'(ny) - longint'(py)))
                  + 67'(sq33(longint'(nz) - longint'(pz)));
            px = nx; py = ny; pz = nz;
            if (shift <= 67'(eps_reg)) begin
                r.status = msms_pkg::STAT_CONV;
                break;
            end
        end
        r.idx = 10'd0;
        best_d2 = '1;
        for (int j = 0; j < pt_count; j++) begin
            d2 = dist_sq(px, py, pz, j);
            if (j == 0 || d2 < best_d2) begin
                best_d2 = d2;
                r.idx   = 10'(j);
            end
        end
        r.x = px; r.y = py; r.z = pz;
        r.passes = 8'(passes);
        return r;
    endfunction

    initial begin
        errors = 0;
        for (int i = 0; i < EXP_N; i++) wtab[i] = exp_entry(i);
    end

    always @(posedge i_clk) begin
        t_mode_result e;
        if (!i_rst_n) begin
            pt_count = 0;
            k_reg    = 32'd65536;
            eps_reg  = 63'd4294967;
            maxp_reg = 8'd100;
            modes_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:3])
                    msms_pkg::REG_K:    k_reg    = pwdata[31:0];
                    msms_pkg::REG_EPS:  eps_reg  = pwdata[62:0];
                    msms_pkg::REG_MAXP: maxp_reg = pwdata[7:0];
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready) begin
                if (modes_due.size() == 0) begin
                    $error("result with no query pending");
                    errors++;
                end else begin
                    e = modes_due.pop_front();
                    if (rsp.mode_x !== e.x) begin
                        $error("mode_x: expected %0d, got %0d", e.x, rsp.mode_x);
                        errors++;
                    end
                    if (rsp.mode_y !== e.y) begin
                        $error("mode_y: expected %0d, got %0d", e.y, rsp.mode_y);
                        errors++;
                    end
                    if (rsp.mode_z !== e.z) begin
                        $error("mode_z: expected %0d, got %0d", e.z, rsp.mode_z);
                        errors++;
                    end
                    if (rsp.nearest_index !== e.idx) begin
                        $error("nearest_index: expected %0d, got %0d", e.idx,
                               rsp.nearest_index);
                        errors++;
                    end
                    if (rsp.passes_used !== e.passes) begin
                        $error("passes_used: expected %0d, got %0d", e.passes,
                               rsp.passes_used);
                        errors++;
                    end
                    if (rsp.status !== e.status) begin
                        $error("status: expected %0d, got %0d", e.status, rsp.status);
                        errors++;
                    end
                end
            end
            if (req.valid && req.ready) begin
                case (req.func)
                    msms_pkg::FUNC_CLEAR:  pt_count = 0;
                    msms_pkg::FUNC_APPEND: begin
                        if (pt_count < MAX_PTS) begin
                            pts_x[pt_count] = req.coord_x;
                            pts_y[pt_count] = req.coord_y;
                            pts_z[pt_count] = req.coord_z;
                            pt_count++;
                        end
                    end
                    msms_pkg::FUNC_QUERY:  modes_due.push_back(seek_mode(req.coord_x,
                                                               req.coord_y, req.coord_z));
                    default: ;
                endcase
            end
        end
    end
endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Mode seeker testbench: directed corner requests, then random clustered
// point sets and queries under several register settings, with bursty
// requests and a stalling result sink. Checking lives in msms_checker.
// ----------------------------------------------------------------------------
module tb;
    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [msms_pkg::ADDR_W-1:0]   paddr;
    logic [msms_pkg::DATA_W-1:0]   pwdata;
    logic [msms_pkg::DATA_W-1:0]   prdata;
    logic                          pready;
    int                            err_cnt;
    int                            pend_cnt;
    int                            burst_left;
    int                            seg_left;
    int                            seg_mode;
    logic signed [31:0]            cx, cy, cz;

    msms_req_if req_if ();
    msms_rsp_if rsp_if ();

    mean_shift_mode_seek uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    msms_checker chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .o_errors  (err_cnt),
        .o_pending (pend_cnt)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #200ms;
        $display("** mean_shift_mode_seek: FAILED **");
        $finish;
    end

    // result sink: ready runs, random stalls and long stalls
    always @(negedge i_clk) begin
        if (seg_left == 0) begin
            seg_mode = $urandom_range(0, 2);
            seg_left = $urandom_range(4, 40);
        end
        seg_left--;
        case (seg_mode)
            0:       rsp_if.ready <= 1'b1;
            1:       rsp_if.ready <= 1'($urandom_range(0, 1));
            default: rsp_if.ready <= (seg_left % 9 == 0);
        endcase
    end

    // called at a falling edge; valid from an accepted request is replaced here
    task automatic send_req(logic [1:0] f, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        if (burst_left == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(8, 30) : $urandom_range(1, 4))
                @(negedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        req_if.func    <= f;
        req_if.coord_x <= x;
        req_if.coord_y <= y;
        req_if.coord_z <= z;
        req_if.valid   <= 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
        burst_left--;
    endtask

    // drain all results, then let a trailing clear or append finish
    task automatic settle();
        req_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pend_cnt != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic wr_reg(logic [1:0] idx, logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [31:0] near(logic [31:0] c, int spread);
        return c + 32'($signed($urandom_range(0, 2 * spread)) - spread);
    endfunction

    initial begin
        int n_pts, n_q;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        req_if.valid = 1'b0; req_if.func = msms_pkg::FUNC_CLEAR;
        req_if.coord_x = '0; req_if.coord_y = '0; req_if.coord_z = '0;
        rsp_if.ready = 1'b0;
        burst_left = 0; seg_left = 0; seg_mode = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: empty store, extremes, func 3, nearest tie
        send_req(msms_pkg::FUNC_QUERY, 32'h0, 32'h0, 32'h0);
        send_req(msms_pkg::FUNC_APPEND, 32'h0, 32'h0, 32'h0);
        send_req(msms_pkg::FUNC_APPEND, 32'h10000, 32'h0, 32'h0);
        send_req(msms_pkg::FUNC_APPEND, 32'h0, 32'h10000, 32'h0);
        send_req(msms_pkg::FUNC_APPEND, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_req(msms_pkg::FUNC_APPEND, 32'h80000000, 32'h80000000, 32'h80000000);
        send_req(2'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_req(msms_pkg::FUNC_QUERY, 32'h4000, 32'h4000, 32'h0);
        send_req(msms_pkg::FUNC_QUERY, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_req(msms_pkg::FUNC_QUERY, 32'h80000000, 32'h80000000, 32'h80000000);
        send_req(msms_pkg::FUNC_APPEND, 32'h0, 32'h0, 32'h0);
        send_req(msms_pkg::FUNC_QUERY, 32'h0, 32'h0, 32'h0);
        send_req(msms_pkg::FUNC_CLEAR, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_req(msms_pkg::FUNC_QUERY, 32'h5, 32'h5, 32'h5);
        settle();

        // zero k gives the plain mean; converge and limit on the same pass
        wr_reg(msms_pkg::REG_K, 64'd0);
        wr_reg(msms_pkg::REG_EPS, 64'h7fffffffffffffff);
        wr_reg(msms_pkg::REG_MAXP, 64'd1);
        send_req(msms_pkg::FUNC_APPEND, 32'h30000, 32'hfffe0000, 32'h1);
        send_req(msms_pkg::FUNC_APPEND, 32'hfff00000, 32'h7fffffff, 32'h2);
        send_req(msms_pkg::FUNC_APPEND, 32'h12345, 32'h80000000, 32'h4);
        send_req(msms_pkg::FUNC_QUERY, 32'h0, 32'h0, 32'h0);
        settle();
        wr_reg(msms_pkg::REG_MAXP, 64'd0);
        send_req(msms_pkg::FUNC_QUERY, 32'h1000, 32'h2000, 32'h3000);
        settle();

        // largest k, zero eps, most passes
        wr_reg(msms_pkg::REG_K, 64'hffffffff);
        wr_reg(msms_pkg::REG_EPS, 64'd0);
        wr_reg(msms_pkg::REG_MAXP, 64'd255);
        send_req(msms_pkg::FUNC_QUERY, 32'h30000, 32'hfffe0000, 32'h1);
        send_req(msms_pkg::FUNC_QUERY, 32'h30001, 32'hfffe0000, 32'h1);
        settle();

        // random phases: clustered point sets with random content, plus noise
        for (int ph = 0; ph < 5; ph++) begin
            wr_reg(msms_pkg::REG_K, $urandom_range(0, 4) == 0 ? 64'($urandom)
                                     : 64'($urandom_range(0, 32'h30000)));
            wr_reg(msms_pkg::REG_EPS, {1'b0, 31'($urandom), $urandom} >> $urandom_range(0, 62));
            wr_reg(msms_pkg::REG_MAXP, $urandom_range(0, 9) == 0 ? 64'd255
                                        : 64'($urandom_range(1, 30)));
            cx = $urandom; cy = $urandom; cz = $urandom;
            if ($urandom_range(0, 9) < 7)
                send_req(msms_pkg::FUNC_CLEAR, $urandom, $urandom, $urandom);
            n_pts = $urandom_range(2, 24);
            for (int i = 0; i < n_pts; i++)
                send_req(msms_pkg::FUNC_APPEND, near(cx, 32'h30000), near(cy, 32'h30000),
                         near(cz, 32'h30000));
            n_q = $urandom_range(2, 5);
            for (int i = 0; i < n_q; i++) begin
                case ($urandom_range(0, 7))
                    0: send_req(2'd3, $urandom, $urandom, $urandom);
                    1: send_req(msms_pkg::FUNC_APPEND, $urandom, $urandom, $urandom);
                    2: send_req(msms_pkg::FUNC_QUERY, $urandom, $urandom, $urandom);
                    default: send_req(msms_pkg::FUNC_QUERY, near(cx, 32'h40000),
                                      near(cy, 32'h40000), near(cz, 32'h40000));
                endcase
            end
            settle();
        end

        repeat (50) @(negedge i_clk);
        if (err_cnt == 0 && pend_cnt == 0) begin
            $display("** mean_shift_mode_seek: PASSED **");
        end else begin
            $display("** mean_shift_mode_seek: FAILED **");
        end
        $finish;
    end
endmodule

// ----- mean_shift_mode_seek.f -----
+incdir+src
src/msms_pkg.sv
src/msms_req_if.sv
src/msms_rsp_if.sv
src/msms_ram.sv
src/msms_div.sv
src/mean_shift_mode_seek.sv
sim/msms_checker.sv
sim/tb.sv
